/* design/crt_congruence_merger_unit_assert.svh */
// assertion macros for the congruence merger
`ifndef CRT_CONGRUENCE_MERGER_UNIT_ASSERT_SVH
`define CRT_CONGRUENCE_MERGER_UNIT_ASSERT_SVH

// condition must never hold outside reset
`define CCM_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CCM_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* design/ccm_pkg.sv */
// shared constants and types of the congruence merger
package ccm_pkg;

   localparam int CCM_VALUE_BITS = 63;
   localparam int STEP_BITS = 5;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOSOL = 2'd1;
   localparam logic [1:0] ST_OVF   = 2'd2;

   // sequencer steps
   localparam logic [STEP_BITS-1:0] S_IDLE   = 5'd0;
   localparam logic [STEP_BITS-1:0] S_RED    = 5'd1;
   localparam logic [STEP_BITS-1:0] S_DISP   = 5'd2;
   localparam logic [STEP_BITS-1:0] S_GCDCHK = 5'd3;
   localparam logic [STEP_BITS-1:0] S_GCD    = 5'd4;
   localparam logic [STEP_BITS-1:0] S_DIVG   = 5'd5;
   localparam logic [STEP_BITS-1:0] S_CHK1   = 5'd6;
   localparam logic [STEP_BITS-1:0] S_MG     = 5'd7;
   localparam logic [STEP_BITS-1:0] S_LIM    = 5'd8;
   localparam logic [STEP_BITS-1:0] S_CHK2   = 5'd9;
   localparam logic [STEP_BITS-1:0] S_N      = 5'd10;
   localparam logic [STEP_BITS-1:0] S_LCM    = 5'd11;
   localparam logic [STEP_BITS-1:0] S_CHK3   = 5'd12;
   localparam logic [STEP_BITS-1:0] S_D      = 5'd13;
   localparam logic [STEP_BITS-1:0] S_INVA   = 5'd14;
   localparam logic [STEP_BITS-1:0] S_EUCCHK = 5'd15;
   localparam logic [STEP_BITS-1:0] S_EUC    = 5'd16;
   localparam logic [STEP_BITS-1:0] S_EUCM   = 5'd17;
   localparam logic [STEP_BITS-1:0] S_K      = 5'd18;
   localparam logic [STEP_BITS-1:0] S_SOL    = 5'd19;
   localparam logic [STEP_BITS-1:0] S_OUT    = 5'd20;

   typedef struct packed {
      logic                 launch;
      logic                 accept;
      logic [STEP_BITS-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic start_sys;
      logic fail_nz;
      logic y_zero;
      logic rem_nz;
      logic over;
      logic n_one;
   } stat_type;

endpackage

/* design/ccm_div.sv */
// restoring divider, one quotient bit per cycle
module ccm_div #(
   parameter int VALUE_BITS = ccm_pkg::CCM_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [VALUE_BITS-1:0] divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quot,
   output logic [VALUE_BITS-1:0] rem
);
   import ccm_pkg::*;

   localparam int W  = VALUE_BITS;
   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [W:0]    sh;
   logic [W+1:0]  sub;
   logic          ge;

   // one shift-subtract step
   always_comb begin
      sh  = {rem_ff, quo_ff[W-1]};
      sub = {1'b0, sh} - {2'b0, dsr_ff};
      ge  = !sub[W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? sub[W-1:0] : sh[W-1:0];
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

/* design/ccm_mul.sv */
// shift-add multiplier, plain or modulo n, one multiplier bit per cycle
module ccm_mul #(
   parameter int VALUE_BITS = ccm_pkg::CCM_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  mod_mode,
   input  logic [VALUE_BITS-1:0] op_a,
   input  logic [VALUE_BITS-1:0] op_b,
   input  logic [VALUE_BITS-1:0] op_n,
   output logic                  done,
   output logic [VALUE_BITS-1:0] prod
);
   import ccm_pkg::*;

   localparam int W = VALUE_BITS;

   logic         busy_ff, busy_in, done_ff, done_in, mm_ff, mm_in;
   logic [W-1:0] acc_ff, acc_in, a_ff, a_in, b_ff, b_in, n_ff, n_in;
   logic [W:0]   sum_acc, sum_a;
   logic [W-1:0] acc_nx, a_nx;

   // add, then fold back once below n in modulo mode
   always_comb begin
      sum_acc = {1'b0, acc_ff} + {1'b0, a_ff};
      sum_a   = {1'b0, a_ff} + {1'b0, a_ff};
      acc_nx  = sum_acc[W-1:0];
      a_nx    = sum_a[W-1:0];
      if (mm_ff) begin
         if (sum_acc >= {1'b0, n_ff}) acc_nx = W'(sum_acc - {1'b0, n_ff});
         if (sum_a >= {1'b0, n_ff}) a_nx = W'(sum_a - {1'b0, n_ff});
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mm_in   = mm_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      n_in    = n_ff;
      if (start) begin
         busy_in = 1'b1;
         mm_in   = mod_mode;
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         n_in    = op_n;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) acc_in = acc_nx;
            a_in = a_nx;
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mm_ff  <= mm_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      n_ff   <= n_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

/* design/ccm_dpath.sv */
// datapath: running congruence, merge operands, shared divider and multiplier
module ccm_dpath #(
   parameter int VALUE_BITS = ccm_pkg::CCM_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ccm_pkg::cmd_type      cmd,
   output ccm_pkg::stat_type     stat,
   input  logic                  req_start_system,
   input  logic [VALUE_BITS-1:0] req_residue,
   input  logic [VALUE_BITS-1:0] req_modulus,
   output logic [VALUE_BITS-1:0] rsp_solution,
   output logic [VALUE_BITS-1:0] rsp_combined_modulus,
   output logic [1:0]            rsp_status
);
   import ccm_pkg::*;

   localparam int W = VALUE_BITS;

   // running state
   logic [W-1:0] a1_ff, a1_in, m1_ff, m1_in;
   logic [1:0]   fail_ff, fail_in;
   // per-item work registers
   logic         start_ff, start_in, neg_ff, neg_in, rnz_ff, rnz_in;
   logic [W-1:0] res_ff, res_in, a2_ff, a2_in, m2_ff, m2_in;
   logic [W-1:0] x_ff, x_in, y_ff, y_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [W-1:0] g_ff, g_in, diff_ff, diff_in, mg_ff, mg_in, lim_ff, lim_in;
   logic [W-1:0] dq_ff, dq_in, n_ff, n_in, lcm_ff, lcm_in;
   logic [W-1:0] d_ff, d_in, q_ff, q_in, k_ff, k_in;
   logic [W-1:0] sol_ff, sol_in, cm_ff, cm_in;
   logic [1:0]   st_ff, st_in;

   logic         div_start, div_done, mul_start, mul_done, mul_mod;
   logic [W-1:0] div_a, div_b, quot, rem, mul_a, mul_b, prod, sum_sol;

   // operand select for the shared units
   always_comb begin
      div_a   = x_ff;
      div_b   = y_ff;
      mul_a   = mg_ff;
      mul_b   = m2_ff;
      mul_mod = 1'b0;
      case (cmd.step)
         S_RED: begin
            div_a = res_ff;
            div_b = m2_ff;
         end
         S_DIVG: begin
            div_a = diff_ff;
            div_b = g_ff;
         end
         S_MG: begin
            div_a = m1_ff;
            div_b = g_ff;
         end
         S_LIM: begin
            div_a = '1;
            div_b = m2_ff;
         end
         S_N: begin
            div_a = m2_ff;
            div_b = g_ff;
         end
         S_D: begin
            div_a = dq_ff;
            div_b = n_ff;
         end
         S_INVA: begin
            div_a = mg_ff;
            div_b = n_ff;
         end
         S_EUCM: begin
            mul_a   = q_ff;
            mul_b   = t1_ff;
            mul_mod = 1'b1;
         end
         S_K: begin
            mul_a   = d_ff;
            mul_b   = t0_ff;
            mul_mod = 1'b1;
         end
         S_SOL: begin
            mul_a = m1_ff;
            mul_b = k_ff;
         end
         default: ;
      endcase
      mul_start = cmd.launch && (cmd.step inside {S_LCM, S_EUCM, S_K, S_SOL});
      div_start = cmd.launch && !(cmd.step inside {S_LCM, S_EUCM, S_K, S_SOL});
   end

   ccm_div #(.VALUE_BITS(W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quot     (quot),
      .rem      (rem)
   );

   ccm_mul #(.VALUE_BITS(W)) u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (mul_start),
      .mod_mode (mul_mod),
      .op_a     (mul_a),
      .op_b     (mul_b),
      .op_n     (n_ff),
      .done     (mul_done),
      .prod     (prod)
   );

   assign sum_sol = a1_ff + prod;

   // register updates per step
   always_comb begin
      a1_in = a1_ff;  m1_in = m1_ff;  fail_in = fail_ff;
      start_in = start_ff;  neg_in = neg_ff;  rnz_in = rnz_ff;
      res_in = res_ff;  a2_in = a2_ff;  m2_in = m2_ff;
      x_in = x_ff;  y_in = y_ff;  t0_in = t0_ff;  t1_in = t1_ff;
      g_in = g_ff;  diff_in = diff_ff;  mg_in = mg_ff;  lim_in = lim_ff;
      dq_in = dq_ff;  n_in = n_ff;  lcm_in = lcm_ff;
      d_in = d_ff;  q_in = q_ff;  k_in = k_ff;
      sol_in = sol_ff;  cm_in = cm_ff;  st_in = st_ff;

      // input transfer, zero modulus counts as one
      if (cmd.accept) begin
         start_in = req_start_system;
         res_in   = req_residue;
         m2_in    = (req_modulus == '0) ? W'(1) : req_modulus;
      end

      case (cmd.step)
         S_DISP: begin
            if (start_ff) begin
               fail_in = ST_OK;
               a1_in   = a2_ff;
               m1_in   = m2_ff;
               sol_in  = a2_ff;
               cm_in   = m2_ff;
               st_in   = ST_OK;
            end else if (fail_ff != ST_OK) begin
               sol_in = '0;
               cm_in  = '0;
               st_in  = fail_ff;
            end else begin
               x_in    = m1_ff;
               y_in    = m2_ff;
               neg_in  = a2_ff < a1_ff;
               diff_in = (a2_ff < a1_ff) ? a1_ff - a2_ff : a2_ff - a1_ff;
            end
         end
         S_GCDCHK: g_in = x_ff;
         S_CHK1: begin
            if (rnz_ff) begin
               fail_in = ST_NOSOL;
               sol_in  = '0;
               cm_in   = '0;
               st_in   = ST_NOSOL;
            end
         end
         S_CHK2: begin
            if (mg_ff > lim_ff) begin
               fail_in = ST_OVF;
               sol_in  = '0;
               cm_in   = '0;
               st_in   = ST_OVF;
            end
         end
         S_CHK3: k_in = '0;
         default: ;
      endcase

      // divider results
      if (div_done) begin
         case (cmd.step)
            S_RED: a2_in = rem;
            S_GCD: begin
               x_in = y_ff;
               y_in = rem;
            end
            S_DIVG: begin
               dq_in  = quot;
               rnz_in = rem != '0;
            end
            S_MG:  mg_in  = quot;
            S_LIM: lim_in = quot;
            S_N:   n_in   = quot;
            S_D:   d_in   = (neg_ff && rem != '0) ? n_ff - rem : rem;
            S_INVA: begin
               x_in  = n_ff;
               y_in  = rem;
               t0_in = '0;
               t1_in = W'(1);
            end
            S_EUC: begin
               q_in = (quot == n_ff) ? '0 : quot;
               x_in = y_ff;
               y_in = rem;
            end
            default: ;
         endcase
      end

      // multiplier results
      if (mul_done) begin
         case (cmd.step)
            S_LCM: lcm_in = prod;
            S_EUCM: begin
               t0_in = t1_ff;
               t1_in = (t0_ff >= prod) ? t0_ff - prod : n_ff - (prod - t0_ff);
            end
            S_K: k_in = prod;
            S_SOL: begin
               a1_in  = sum_sol;
               m1_in  = lcm_ff;
               sol_in = sum_sol;
               cm_in  = lcm_ff;
               st_in  = ST_OK;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_ff   <= '0;
         m1_ff   <= W'(1);
         fail_ff <= ST_OK;
      end else begin
         a1_ff   <= a1_in;
         m1_ff   <= m1_in;
         fail_ff <= fail_in;
      end
      start_ff <= start_in;  neg_ff <= neg_in;  rnz_ff <= rnz_in;
      res_ff <= res_in;  a2_ff <= a2_in;  m2_ff <= m2_in;
      x_ff <= x_in;  y_ff <= y_in;  t0_ff <= t0_in;  t1_ff <= t1_in;
      g_ff <= g_in;  diff_ff <= diff_in;  mg_ff <= mg_in;  lim_ff <= lim_in;
      dq_ff <= dq_in;  n_ff <= n_in;  lcm_ff <= lcm_in;
      d_ff <= d_in;  q_ff <= q_in;  k_ff <= k_in;
      sol_ff <= sol_in;  cm_ff <= cm_in;  st_ff <= st_in;
   end

   // status back to the controller
   always_comb begin
      stat.done      = div_done | mul_done;
      stat.start_sys = start_ff;
      stat.fail_nz   = fail_ff != ST_OK;
      stat.y_zero    = y_ff == '0;
      stat.rem_nz    = rnz_ff;
      stat.over      = mg_ff > lim_ff;
      stat.n_one     = n_ff == W'(1);
   end

   assign rsp_solution         = sol_ff;
   assign rsp_combined_modulus = cm_ff;
   assign rsp_status           = st_ff;

endmodule

/* design/ccm_ctrl.sv */
// controller: sequences the merge steps and the channel handshakes
module ccm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  ccm_pkg::stat_type stat,
   output ccm_pkg::cmd_type  cmd
);
   import ccm_pkg::*;

   logic [STEP_BITS-1:0] state_ff, state_in;
   logic                 launched_ff, launched_in;
   logic                 unit_step;

   // steps that run the divider or multiplier
   assign unit_step = state_ff inside {S_RED, S_GCD, S_DIVG, S_MG, S_LIM, S_N, S_LCM,
                                       S_D, S_INVA, S_EUC, S_EUCM, S_K, S_SOL};

   always_comb begin
      cmd.step   = state_ff;
      cmd.accept = (state_ff == S_IDLE) && req_valid;
      cmd.launch = unit_step && !launched_ff;
      req_stall  = state_ff != S_IDLE;
      rsp_valid  = state_ff == S_OUT;

      launched_in = launched_ff;
      if (stat.done) launched_in = 1'b0;
      else if (cmd.launch) launched_in = 1'b1;

      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_RED;
         S_RED:    if (stat.done) state_in = S_DISP;
         S_DISP: begin
            if (stat.start_sys || stat.fail_nz) state_in = S_OUT;
            else state_in = S_GCDCHK;
         end
         S_GCDCHK: state_in = stat.y_zero ? S_DIVG : S_GCD;
         S_GCD:    if (stat.done) state_in = S_GCDCHK;
         S_DIVG:   if (stat.done) state_in = S_CHK1;
         S_CHK1:   state_in = stat.rem_nz ? S_OUT : S_MG;
         S_MG:     if (stat.done) state_in = S_LIM;
         S_LIM:    if (stat.done) state_in = S_CHK2;
         S_CHK2:   state_in = stat.over ? S_OUT : S_N;
         S_N:      if (stat.done) state_in = S_LCM;
         S_LCM:    if (stat.done) state_in = S_CHK3;
         S_CHK3:   state_in = stat.n_one ? S_SOL : S_D;
         S_D:      if (stat.done) state_in = S_INVA;
         S_INVA:   if (stat.done) state_in = S_EUCCHK;
         S_EUCCHK: state_in = stat.y_zero ? S_K : S_EUC;
         S_EUC:    if (stat.done) state_in = S_EUCM;
         S_EUCM:   if (stat.done) state_in = S_EUCCHK;
         S_K:      if (stat.done) state_in = S_SOL;
         S_SOL:    if (stat.done) state_in = S_OUT;
         S_OUT:    if (!rsp_stall) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         launched_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
      end
   end

endmodule

/* design/crt_congruence_merger_unit.sv */
// top level of the congruence merger
// Merges one congruence x = residue (mod modulus) per transfer into a running
// solution and lcm, and returns one result per item. One item is in flight at a
// time. Every divide or modulo uses a shared divider, every product a shift-add
// multiplier. A start item costs one divide plus the accept, dispatch and result
// steps. A full merge costs (10 + G + 2E) units plus G + E + 8 steps that use
// no unit, where G is the number of Euclid steps of the gcd and E those of the
// modular inverse; a modulus ratio of one skips the inverse. The worst case for
// 63-bit values is set by those two Euclid loops. A sticky failure answers a
// merge after one divide.
module crt_congruence_merger_unit #(
   parameter int VALUE_BITS = ccm_pkg::CCM_VALUE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_start_system,
   input  logic [VALUE_BITS-1:0] req_residue,
   input  logic [VALUE_BITS-1:0] req_modulus,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_solution,
   output logic [VALUE_BITS-1:0] rsp_combined_modulus,
   output logic [1:0]            rsp_status
);
   import ccm_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ccm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ccm_dpath #(.VALUE_BITS(VALUE_BITS)) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_start_system     (req_start_system),
      .req_residue          (req_residue),
      .req_modulus          (req_modulus),
      .rsp_solution         (rsp_solution),
      .rsp_combined_modulus (rsp_combined_modulus),
      .rsp_status           (rsp_status)
   );

`include "crt_congruence_merger_unit_assert.svh"

   // a result never waits while a new item is taken
   `CCM_NEVER(a_no_overlap, rsp_valid && !req_stall, "input taken while result pending")
   // status code three is never produced
   `CCM_NEVER(a_status_code, rsp_valid && rsp_status == 2'd3, "invalid status code")
   // failures report zero payload
   `CCM_IMPLY(a_fail_zero, rsp_valid && rsp_status != ST_OK, rsp_solution == '0 && rsp_combined_modulus == '0, "failure with nonzero payload")
   // solution stays below the combined modulus
   `CCM_IMPLY(a_sol_range, rsp_valid && rsp_status == ST_OK, rsp_solution < rsp_combined_modulus, "solution out of range")

endmodule

/* dv/tb_top.sv */
// self-checking testbench of the congruence merger: random systems, stalls and gaps
`timescale 1ns / 1ps

module tb_top;
   import ccm_pkg::*;

   localparam int VB = CCM_VALUE_BITS;
   localparam logic [127:0] VAL_MAX = (128'd1 << VB) - 1;

   typedef struct {
      bit          start;
      bit [VB-1:0] residue;
      bit [VB-1:0] modulus;
      bit          drain_first;
   } congruence_type;

   typedef struct {
      logic [VB-1:0] solution;
      logic [VB-1:0] lcm;
      logic [1:0]    status;
   } merge_result_type;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_valid = 0;
   logic          req_stall;
   logic          req_start_system = 0;
   logic [VB-1:0] req_residue = '0;
   logic [VB-1:0] req_modulus = '0;
   logic          rsp_valid;
   logic          rsp_stall = 0;
   logic [VB-1:0] rsp_solution;
   logic [VB-1:0] rsp_combined_modulus;
   logic [1:0]    rsp_status;

   congruence_type   congruence_q[$];
   merge_result_type expected_merges[$];
   congruence_type   cur_item;

   // running pair of the predictor
   logic [127:0] pred_solution = 0;
   logic [127:0] pred_modulus = 1;
   logic [1:0]   pred_failure = ST_OK;

   int  errors = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  nosol_seen = 0;
   int  ovf_seen = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   bit  calm = 0;
   bit  long_hold = 0;

   crt_congruence_merger_unit i_dut (.*);

   initial forever #6 clock = ~clock;

   function automatic logic [127:0] gcd128(logic [127:0] a, logic [127:0] b);
      logic [127:0] r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   // inverse of a modulo n by extended euclid, gcd(a, n) == 1
   function automatic logic [127:0] inverse_mod(logic [127:0] a, logic [127:0] n);
      logic [127:0]        r0, r1, r2, q;
      logic signed [127:0] t0, t1, t2;
      r0 = n;
      r1 = a % n;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
         q = r0 / r1;
         r2 = r0 - q * r1;
         t2 = t0 - $signed(q) * t1;
         r0 = r1; r1 = r2;
         t0 = t1; t1 = t2;
      end
      if (t0 < 0) t0 = t0 + $signed(n);
      return t0;
   endfunction

   // merge one accepted congruence into the predicted pair and queue its result
   task automatic merge_congruence(congruence_type c);
      logic [127:0]     m1, m2, a1, a2, g, diff, n, lcm, d, k;
      bit               neg;
      merge_result_type r;
      m2 = c.modulus;
      if (m2 == 0) m2 = 1;
      a2 = c.residue % m2;
      r.solution = 0;
      r.lcm = 0;
      r.status = ST_OK;
      if (c.start) begin
         pred_failure = ST_OK;
         pred_solution = a2;
         pred_modulus = m2;
         r.solution = a2;
         r.lcm = m2;
      end else if (pred_failure != ST_OK) begin
         r.status = pred_failure;
      end else begin
         m1 = pred_modulus;
         a1 = pred_solution;
         g = gcd128(m1, m2);
         neg = a2 < a1;
         diff = neg ? a1 - a2 : a2 - a1;
         if (diff % g != 0) begin
            pred_failure = ST_NOSOL;
         end else if (m1 / g > VAL_MAX / m2) begin
            pred_failure = ST_OVF;
         end else begin
            n = m2 / g;
            lcm = (m1 / g) * m2;
            k = 0;
            if (n != 1) begin
               d = (diff / g) % n;
               if (neg && d != 0) d = n - d;
               k = (d * inverse_mod((m1 / g) % n, n)) % n;
            end
            pred_solution = a1 + m1 * k;
            pred_modulus = lcm;
            r.solution = pred_solution;
            r.lcm = lcm;
         end
         r.status = pred_failure;
      end
      expected_merges.push_back(r);
   endtask

   task automatic report_mismatch(string what, logic [VB-1:0] got, logic [VB-1:0] want);
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
               results_seen);
      errors++;
   endtask

   task automatic add_item(bit s, bit [VB-1:0] r, bit [VB-1:0] m, bit drain = 0);
      congruence_type c;
      c.start = s;
      c.residue = r;
      c.modulus = m;
      c.drain_first = drain;
      congruence_q.push_back(c);
   endtask

   function automatic bit [VB-1:0] rand_value();
      return VB'({$urandom(), $urandom()});
   endfunction

   // mostly small moduli so that euclid loops stay short, a few at full width
   function automatic bit [VB-1:0] rand_modulus();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return VB'($urandom_range(1, 4096));
      if (pick < 95) return VB'($urandom_range(1, 1 << 20));
      return rand_value() | 1;
   endfunction

   // residue for x mod m, sometimes lifted above the modulus by a multiple of it
   function automatic bit [VB-1:0] lift_residue(bit [VB-1:0] x, bit [VB-1:0] m);
      bit [VB-1:0] v;
      if ($urandom_range(0, 9) < 7) return x % m;
      v = rand_value();
      return v - (v % m) + (x % m);
   endfunction

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            merge_congruence(cur_item);
            items_sent++;
            send_gap = calm ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 39) == 0) calm <= !calm;
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 0;
            end else if (congruence_q.size() > 0 &&
                         !(congruence_q[0].drain_first && expected_merges.size() > 0)) begin
               cur_item = congruence_q.pop_front();
               req_valid <= 1;
               req_start_system <= cur_item.start;
               req_residue <= cur_item.residue;
               req_modulus <= cur_item.modulus;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      merge_result_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_merges.size() == 0) begin
               report_mismatch("unexpected result", rsp_solution, '0);
            end else begin
               e = expected_merges.pop_front();
               if (rsp_solution !== e.solution)
                  report_mismatch("solution", rsp_solution, e.solution);
               if (rsp_combined_modulus !== e.lcm)
                  report_mismatch("combined_modulus", rsp_combined_modulus, e.lcm);
               if (rsp_status !== e.status)
                  report_mismatch("status", rsp_status, e.status);
               if (e.status == ST_NOSOL) nosol_seen++;
               if (e.status == ST_OVF) ovf_seen++;
            end
            results_seen++;
            recv_gap = calm ? 0 : $urandom_range(0, 3);
         end else if (recv_gap > 0) begin
            recv_gap--;
         end
         rsp_stall <= long_hold || (recv_gap > 0);
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (items_sent >= 250);
      @(posedge clock);
      long_hold <= 1;
      repeat (30000) @(posedge clock);
      long_hold <= 0;
   end

   initial begin
      #1000000000;
      $display("timeout");
      $display("FAILED: results differ");
      $finish;
   end

   // stimulus and end of run
   initial begin
      bit [VB-1:0] x, m;
      int          total, len, kind;
      // directed: merge after reset, extremes, reduction, zero modulus
      add_item(0, 5, 7);
      add_item(0, 3, 11);
      add_item(1, '1, '1);
      add_item(1, '1, 1);
      add_item(1, 100, 7);
      add_item(0, 0, 0);
      add_item(0, 4, 6);
      add_item(1, 2, 4);
      add_item(0, 4, 6);
      add_item(0, 22, 12);
      // no solution, then sticky, then cleared by a start
      add_item(1, 1, 4);
      add_item(0, 2, 6);
      add_item(0, 0, 3);
      add_item(1, 0, 3);
      // lcm overflow, sticky
      add_item(1, 12345, 63'h4000_0000_0000_0001);
      add_item(0, 7, 63'h3fff_ffff_ffff_fff1);
      add_item(0, 1, 5);
      // full-width merge that fits, with a negative difference
      add_item(1, 63'h7fff_fffe, 63'h7fff_ffff);
      add_item(0, 3, 63'h8000_0000);
      add_item(0, '1, 2, 1);
      add_item(1, '0, '1);
      add_item(0, '1, '1);
      total = congruence_q.size();
      // random part
      while (total < 600) begin
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            x = rand_value();
            len = $urandom_range(2, 6);
            for (int i = 0; i < len; i++) begin
               m = rand_modulus();
               add_item(i == 0, lift_residue(x, m), m, total == 350);
               total++;
            end
         end else if (kind < 85) begin
            add_item($urandom_range(0, 1), rand_value(), rand_modulus());
            total++;
         end else if (kind < 92) begin
            add_item(1, rand_value(), rand_value() >> $urandom_range(0, 20));
            add_item(0, rand_value(), rand_value() >> $urandom_range(0, 20));
            total += 2;
         end else begin
            add_item(1, rand_value(), rand_value());
            total++;
         end
      end
      repeat (3) @(posedge clock);
      reset <= 0;
      wait (items_sent == total);
      wait (expected_merges.size() == 0);
      repeat (20000) @(posedge clock);
      $display("ran %0d congruences, %0d results checked", items_sent, results_seen);
      $display("no-solution results %0d, overflow results %0d", nosol_seen, ovf_seen);
      if (errors == 0 && expected_merges.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
